@@ rtl/core/apiv_pkg.sv @@
// Shared constants and register codes for the annular inlet velocity pipeline.
package apiv_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int VELOCITY_BITS_DEF = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int NORMAL_W   = 16;
    localparam int RADIUS_W   = 24;
    localparam int SPEED_W    = 22;
    localparam int STEP_W     = 32;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 48;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CENTRE_X = 3'd0,
        CFG_CENTRE_Y = 3'd1,
        CFG_CENTRE_Z = 3'd2,
        CFG_NORMAL   = 3'd3,
        CFG_OUTER_R  = 3'd4,
        CFG_INNER_R  = 3'd5,
        CFG_MAX_SPD  = 3'd6,
        CFG_WARMUP   = 3'd7
    } t_cfg_reg;

endpackage

@@ rtl/core/annular_parabolic_inlet_velocity.sv @@
// Top level: pipelined annular parabolic inlet velocity per lattice site.
// Pipe: 93 register stages, the first loaded at the accept edge; 32 of them one root bit
// each, 48 of them one quotient bit each, the last one the output register.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Reset (synchronous, active low) empties the pipe and clears the configuration registers.
module annular_parabolic_inlet_velocity
    import apiv_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pos_x, pos_y, pos_z, time_step
    input  logic [((3*POSITION_BITS+STEP_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // vel_x, vel_y, vel_z
    output logic [((3*VELOCITY_BITS+7)/8)*8-1:0] m_axis_tdata,
    // saturated, degenerate
    output logic [1:0]            m_axis_tuser
);

    localparam int P      = POSITION_BITS;
    localparam int V      = VELOCITY_BITS;
    localparam int OUT_W  = ((3*V+7)/8)*8;
    localparam int DW     = P + 1;
    localparam int PROD_W = DW + NORMAL_W;
    localparam int ZS_W   = PROD_W + 2;
    localparam int SQ_W   = 2 * DW;
    localparam int SS_W   = SQ_W + 2;

    localparam int ST_D    = 0;
    localparam int ST_PROD = 1;
    localparam int ST_AZ   = 2;
    localparam int ST_Z2   = 3;
    localparam int ST_R2   = 4;
    localparam int ST_SQ0  = 5;
    localparam int ST_PA   = ST_SQ0 + SQRT_STEPS;
    localparam int ST_MUL  = ST_PA + 1;
    localparam int ST_PP   = ST_MUL + 1;
    localparam int ST_NUM  = ST_PP + 1;
    localparam int ST_DIV0 = ST_NUM + 1;
    localparam int ST_MAG  = ST_DIV0 + 1 + DIV_STEPS;
    localparam int ST_C    = ST_MAG + 1;
    localparam int NS      = ST_C + 1;

    localparam logic signed [64:0] VEL_MAX = 65'((65'd1 <<< (V-1)) - 65'd1);
    localparam logic signed [64:0] VEL_MIN = -65'sd1 * 65'(65'd1 <<< (V-1));

    typedef struct packed {
        logic [STEP_W-1:0] t;
        logic [DW-1:0]     dx, dy, dz;
        logic [PROD_W-1:0] px, py, pz;
        logic [SQ_W-1:0]   sx, sy, sz;
        logic [31:0]       az;
        logic [63:0]       dd;
        logic [63:0]       z2;
        logic [53:0]       nm;
        logic              lt;
        logic [63:0]       v;
        logic [63:0]       res;
        logic [32:0]       wr;
        logic [21:0]       vq;
        logic [31:0]       pa_a, pb_a;
        logic              ppos;
        logic [21:0]       vm;
        logic [62:0]       pabs;
        logic [47:0]       q;
        logic [56:0]       lo;
        logic [55:0]       hi;
        logic [87:0]       num;
        logic [49:0]       rem;
        logic [47:0]       quo;
        logic              over;
        logic [47:0]       mag;
        logic              neg;
        logic [64:0]       cx, cy, cz;
    } t_pipe;

    logic [P-1:0]        r_cx, r_cy, r_cz;
    logic [47:0]         r_norm;
    logic [RADIUS_W-1:0] r_ro, r_ri;
    logic [SPEED_W-1:0]  r_vmax;
    logic [STEP_W-1:0]   r_warm;

    t_pipe       r_p [NS];
    t_pipe       n_p [NS];
    t_pipe       s_in [NS];
    logic [NS-1:0] r_v;
    logic        r_ov;
    logic [V-1:0] r_vx, r_vy, r_vz;
    logic        r_sat, r_deg;
    logic        en;

    logic signed [NORMAL_W-1:0] nx, ny, nz;
    logic [49:0] dq;

    assign nx = r_norm[15:0];
    assign ny = r_norm[31:16];
    assign nz = r_norm[47:32];
    assign dq = {1'b0, r_p[ST_NUM].q, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_cz <= '0; r_norm <= '0;
            r_ro <= '0; r_ri <= '0; r_vmax <= '0; r_warm <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_CENTRE_X: r_cx   <= i_cfg_wdata[P-1:0];
                CFG_CENTRE_Y: r_cy   <= i_cfg_wdata[P-1:0];
                CFG_CENTRE_Z: r_cz   <= i_cfg_wdata[P-1:0];
                CFG_NORMAL:   r_norm <= i_cfg_wdata[47:0];
                CFG_OUTER_R:  r_ro   <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_INNER_R:  r_ri   <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_MAX_SPD:  r_vmax <= i_cfg_wdata[SPEED_W-1:0];
                CFG_WARMUP:   r_warm <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    always_comb begin
        s_in[0]    = '0;
        s_in[0].t  = s_axis_tdata[3*P +: STEP_W];
        s_in[0].dx = {s_axis_tdata[P-1], s_axis_tdata[P-1:0]};
        s_in[0].dy = {s_axis_tdata[2*P-1], s_axis_tdata[P +: P]};
        s_in[0].dz = {s_axis_tdata[3*P-1], s_axis_tdata[2*P +: P]};
    end

    for (genvar k = 1; k < NS; k++) begin : g_src
        assign s_in[k] = r_p[k-1];
    end

    for (genvar k = 0; k < NS; k++) begin : g_st
        if (k == ST_D) begin : g_d
            always_comb begin
                n_p[k]    = s_in[k];
                n_p[k].dx = s_in[k].dx - {r_cx[P-1], r_cx};
                n_p[k].dy = s_in[k].dy - {r_cy[P-1], r_cy};
                n_p[k].dz = s_in[k].dz - {r_cz[P-1], r_cz};
            end
        end else if (k == ST_PROD) begin : g_prod
            always_comb begin
                logic [DW-1:0] ux, uy, uz;
                n_p[k] = s_in[k];
                ux = s_in[k].dx[DW-1] ? -s_in[k].dx : s_in[k].dx;
                uy = s_in[k].dy[DW-1] ? -s_in[k].dy : s_in[k].dy;
                uz = s_in[k].dz[DW-1] ? -s_in[k].dz : s_in[k].dz;
                n_p[k].px = $signed({{NORMAL_W{s_in[k].dx[DW-1]}}, s_in[k].dx})
                          * $signed({{DW{nx[NORMAL_W-1]}}, nx});
                n_p[k].py = $signed({{NORMAL_W{s_in[k].dy[DW-1]}}, s_in[k].dy})
                          * $signed({{DW{ny[NORMAL_W-1]}}, ny});
                n_p[k].pz = $signed({{NORMAL_W{s_in[k].dz[DW-1]}}, s_in[k].dz})
                          * $signed({{DW{nz[NORMAL_W-1]}}, nz});
                n_p[k].sx = {{DW{1'b0}}, ux} * {{DW{1'b0}}, ux};
                n_p[k].sy = {{DW{1'b0}}, uy} * {{DW{1'b0}}, uy};
                n_p[k].sz = {{DW{1'b0}}, uz} * {{DW{1'b0}}, uz};
            end
        end else if (k == ST_AZ) begin : g_az
            always_comb begin
                logic signed [ZS_W-1:0] zs, z8;
                logic [ZS_W-1:0] za;
                logic [SS_W-1:0] ss;
                n_p[k] = s_in[k];
                zs = $signed({{2{s_in[k].px[PROD_W-1]}}, s_in[k].px})
                   + $signed({{2{s_in[k].py[PROD_W-1]}}, s_in[k].py})
                   + $signed({{2{s_in[k].pz[PROD_W-1]}}, s_in[k].pz})
                   + ZS_W'(8192);
                z8 = zs >>> 14;
                za = z8[ZS_W-1] ? ZS_W'(-z8) : ZS_W'(z8);
                n_p[k].az = (za > ZS_W'(33'h0FFFFFFFF)) ? 32'hFFFFFFFF : za[31:0];
                ss = SS_W'(s_in[k].sx) + SS_W'(s_in[k].sy) + SS_W'(s_in[k].sz);
                n_p[k].dd = (ss > SS_W'(64'hFFFFFFFFFFFFFFFF)) ? '1 : 64'(ss);
            end
        end else if (k == ST_Z2) begin : g_z2
            always_comb begin
                n_p[k]    = s_in[k];
                n_p[k].z2 = {32'b0, s_in[k].az} * {32'b0, s_in[k].az};
                n_p[k].nm = 54'(r_vmax) * 54'(s_in[k].t);
                n_p[k].lt = s_in[k].t < r_warm;
            end
        end else if (k == ST_R2) begin : g_r2
            always_comb begin
                n_p[k]     = s_in[k];
                n_p[k].v   = (s_in[k].dd > s_in[k].z2) ? s_in[k].dd - s_in[k].z2 : '0;
                n_p[k].res = '0;
                n_p[k].wr  = {1'b0, s_in[k].nm[53:22]};
                n_p[k].vq  = '0;
            end
        end else if (k >= ST_SQ0 && k < ST_PA) begin : g_sq
            localparam int J = k - ST_SQ0;
            localparam logic [63:0] BIT = 64'd1 << (62 - 2*J);
            always_comb begin
                logic [63:0] tr;
                logic [32:0] w2;
                n_p[k] = s_in[k];
                tr = s_in[k].res + BIT;
                if (s_in[k].v >= tr) begin
                    n_p[k].v   = s_in[k].v - tr;
                    n_p[k].res = (s_in[k].res >> 1) + BIT;
                end else begin
                    n_p[k].res = s_in[k].res >> 1;
                end
                w2 = '0;
                if (J < SPEED_W) begin
                    w2 = {s_in[k].wr[31:0], s_in[k].nm[SPEED_W-1-(J % SPEED_W)]};
                    if (w2 >= {1'b0, r_warm}) begin
                        n_p[k].wr = w2 - {1'b0, r_warm};
                        n_p[k].vq = {s_in[k].vq[20:0], 1'b1};
                    end else begin
                        n_p[k].wr = w2;
                        n_p[k].vq = {s_in[k].vq[20:0], 1'b0};
                    end
                end
            end
        end else if (k == ST_PA) begin : g_pa
            always_comb begin
                logic [31:0] r;
                logic [32:0] pa, pb;
                n_p[k] = s_in[k];
                r  = (s_in[k].res > 64'h80000000) ? 32'h80000000 : s_in[k].res[31:0];
                pa = {1'b0, r} - {9'b0, r_ro};
                pb = {1'b0, r} - {9'b0, r_ri};
                n_p[k].pa_a = pa[32] ? 32'(-pa) : pa[31:0];
                n_p[k].pb_a = pb[32] ? 32'(-pb) : pb[31:0];
                n_p[k].ppos = (pa != '0) && (pb != '0) && (pa[32] == pb[32]);
                n_p[k].vm   = s_in[k].lt ? s_in[k].vq : r_vmax;
            end
        end else if (k == ST_MUL) begin : g_mul
            always_comb begin
                logic [24:0] w;
                logic [23:0] wa;
                n_p[k] = s_in[k];
                n_p[k].pabs = 63'(64'(s_in[k].pa_a) * 64'(s_in[k].pb_a));
                w  = {1'b0, r_ro} - {1'b0, r_ri};
                wa = w[24] ? 24'(-w) : w[23:0];
                n_p[k].q = {24'b0, wa} * {24'b0, wa};
            end
        end else if (k == ST_PP) begin : g_pp
            always_comb begin
                logic [24:0] v8;
                n_p[k] = s_in[k];
                v8 = {s_in[k].vm, 3'b0};
                n_p[k].lo = 57'(v8) * 57'(s_in[k].pabs[31:0]);
                n_p[k].hi = 56'(v8) * 56'(s_in[k].pabs[62:32]);
            end
        end else if (k == ST_NUM) begin : g_num
            always_comb begin
                n_p[k]     = s_in[k];
                n_p[k].num = {s_in[k].hi, 32'b0} + 88'(s_in[k].lo) + 88'(s_in[k].q);
            end
        end else if (k == ST_DIV0) begin : g_div0
            always_comb begin
                n_p[k]      = s_in[k];
                n_p[k].rem  = 50'(s_in[k].num[87:48]);
                n_p[k].over = 50'(s_in[k].num[87:48]) >= dq;
                n_p[k].quo  = '0;
            end
        end else if (k > ST_DIV0 && k < ST_MAG) begin : g_div
            localparam int B = DIV_STEPS - 1 - (k - ST_DIV0 - 1);
            always_comb begin
                logic [49:0] r2;
                n_p[k] = s_in[k];
                r2 = {s_in[k].rem[48:0], s_in[k].num[B]};
                if (r2 >= dq) begin
                    n_p[k].rem = r2 - dq;
                    n_p[k].quo = {s_in[k].quo[46:0], 1'b1};
                end else begin
                    n_p[k].rem = r2;
                    n_p[k].quo = {s_in[k].quo[46:0], 1'b0};
                end
            end
        end else if (k == ST_MAG) begin : g_mag
            always_comb begin
                n_p[k]     = s_in[k];
                n_p[k].mag = (s_in[k].over || s_in[k].quo > 48'h800000000000)
                           ? 48'h800000000000 : s_in[k].quo;
                n_p[k].neg = s_in[k].ppos;
            end
        end else begin : g_c
            always_comb begin
                logic [48:0] sv;
                n_p[k] = s_in[k];
                sv = s_in[k].neg ? -{1'b0, s_in[k].mag} : {1'b0, s_in[k].mag};
                n_p[k].cx = $signed({{16{sv[48]}}, sv}) * $signed({{49{nx[15]}}, nx});
                n_p[k].cy = $signed({{16{sv[48]}}, sv}) * $signed({{49{ny[15]}}, ny});
                n_p[k].cz = $signed({{16{sv[48]}}, sv}) * $signed({{49{nz[15]}}, nz});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                r_p[i] <= n_p[i];
            end
        end
    end

    function automatic logic [V:0] vel_sat(input logic [64:0] c);
        logic signed [64:0] z;
        z = $signed(c + 65'd8192) >>> 14;
        if (z > VEL_MAX) begin
            return {1'b1, VEL_MAX[V-1:0]};
        end else if (z < VEL_MIN) begin
            return {1'b1, VEL_MIN[V-1:0]};
        end
        return {1'b0, z[V-1:0]};
    endfunction

    logic [V:0] n_sx, n_sy, n_sz;
    logic       n_deg;

    assign n_sx  = vel_sat(r_p[ST_C].cx);
    assign n_sy  = vel_sat(r_p[ST_C].cy);
    assign n_sz  = vel_sat(r_p[ST_C].cz);
    assign n_deg = (r_ro == r_ri);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx  <= n_deg ? '0 : n_sx[V-1:0];
            r_vy  <= n_deg ? '0 : n_sy[V-1:0];
            r_vz  <= n_deg ? '0 : n_sz[V-1:0];
            r_sat <= !n_deg && (n_sx[V] || n_sy[V] || n_sz[V]);
            r_deg <= n_deg;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_W'({r_vz, r_vy, r_vx});
    assign m_axis_tuser  = {r_deg, r_sat};

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
        else $error("degenerate result carries nonzero velocity");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held back with empty output");

    a_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (r_norm == '0) |-> (m_axis_tdata == '0) && !m_axis_tuser[0])
        else $error("zero normal gave nonzero velocity");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipe moved during stall");

endmodule
